// ===== rtl/dtne_pkg.sv =====
// shared types and constants for the depth test and normal encode block
// no dependencies
package dtne_pkg;

  localparam int ImageWidth  = 256;
  localparam int ImageHeight = 256;
  localparam int AddrW       = 16;
  localparam int DepthW      = 32;
  localparam int InW         = 144;
  localparam int OutW        = 80;

  localparam logic [31:0] TopWord      = 32'hffff7f7f;
  localparam logic [31:0] FlatWord     = 32'hff7f7f7f;
  localparam logic [7:0]  AlphaByte    = 8'hff;
  localparam logic [31:0] TopDepthRst  = 32'h7fffffff;
  localparam logic [31:0] DepthClear   = 32'h80000000;

  typedef enum logic [7:0] {
    StClear  = 8'b00000001,
    StIdle   = 8'b00000010,
    StRead   = 8'b00000100,
    StTest   = 8'b00001000,
    StSquare = 8'b00010000,
    StRoot   = 8'b00100000,
    StDivide = 8'b01000000,
    StDone   = 8'b10000000
  } state_e;

endpackage

// ===== rtl/depth_test_normal_encode.sv =====
// depth-tested surface sample writer with packed rgba normal encoding
// depends on dtne_pkg
//
// channel  dir  width  fields (lowest bit first)
// s_axis   in   144    pixel_x, pixel_y, sample_depth, grad_x, grad_y, grad_z
// m_axis   out  80     out_x, out_y, new_depth, normal_word
// cfg      in   32     top_depth
//
// one sample at a time: a failed depth test goes back to idle, a top-depth hit goes
// straight to the output, a full normal runs 4 square/accumulate, 32 root and
// 8 divide steps, and a zero gradient leaves the divide early with the flat normal
// after reset a clearing pass writes all 65536 depth entries, one per cycle,
// with s_axis_tready low; config writes are taken throughout
// the result sits in an output register, so the next sample is accepted while
// it waits; only a second result waits on m_axis_tready
module depth_test_normal_encode (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pixel_x, pixel_y, sample_depth, grad_x, grad_y, grad_z
  input  logic [dtne_pkg::InW-1:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, new_depth, normal_word
  output logic [dtne_pkg::OutW-1:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i
);

  dtne_pkg::state_e state_q, state_d;

  logic [dtne_pkg::DepthW-1:0] mem [2**dtne_pkg::AddrW];
  logic [31:0] rd_q;
  logic        we;
  logic [dtne_pkg::AddrW-1:0] waddr;
  logic [31:0] wdata;

  logic [dtne_pkg::AddrW-1:0] clr_q;
  logic [31:0] top_q;
  logic [7:0]  x_q, y_q;
  logic signed [31:0] z_q;
  logic signed [31:0] g_q [3];
  logic [1:0]  cnt_q;
  logic [4:0]  step_q;
  logic [63:0] prod_q, acc_q, rem_q, res_q, bit_q;
  logic [40:0] num_q [3];
  logic [7:0]  quo_q [3];
  logic [31:0] word_q;
  logic        ov_q;
  logic [79:0] od_q;

  logic        in_xfer, load_out, in_range;
  logic signed [31:0] g_sel;
  logic [31:0] mag;
  logic [31:0] len;
  logic [63:0] trial;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign load_out = (state_q == dtne_pkg::StDone) && (!ov_q || m_axis_tready);
  assign s_axis_tready = (state_q == dtne_pkg::StIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign in_range = (int'(x_q) < dtne_pkg::ImageWidth) && (int'(y_q) < dtne_pkg::ImageHeight);
  assign len   = res_q[31:0];
  assign trial = res_q + bit_q;

  // magnitude of the gradient component being squared
  always_comb begin
    unique case (cnt_q)
      2'd0:    g_sel = g_q[0];
      2'd1:    g_sel = g_q[1];
      default: g_sel = g_q[2];
    endcase
    mag = (g_sel < 0) ? 32'(-g_sel) : 32'(g_sel);
  end

  // memory write port: clearing pass or depth update
  always_comb begin
    we    = 1'b0;
    waddr = {y_q, x_q};
    wdata = z_q;
    if (state_q == dtne_pkg::StClear) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = dtne_pkg::DepthClear;
    end else if (state_q == dtne_pkg::StTest && in_range && ($signed(rd_q) < z_q)) begin
      we = 1'b1;
    end
  end

  // depth store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[{y_q, x_q}];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtne_pkg::StClear:  if (&clr_q) state_d = dtne_pkg::StIdle;
      dtne_pkg::StIdle:   if (in_xfer) state_d = dtne_pkg::StRead;
      dtne_pkg::StRead:   state_d = dtne_pkg::StTest;
      dtne_pkg::StTest: begin
        if (!we) state_d = dtne_pkg::StIdle;
        else if (z_q == $signed(top_q)) state_d = dtne_pkg::StDone;
        else state_d = dtne_pkg::StSquare;
      end
      dtne_pkg::StSquare: if (cnt_q == 2'd3) state_d = dtne_pkg::StRoot;
      dtne_pkg::StRoot:   if (step_q == 5'd31) state_d = dtne_pkg::StDivide;
      dtne_pkg::StDivide: if (len == 32'd0 || step_q == 5'd7) state_d = dtne_pkg::StDone;
      dtne_pkg::StDone:   if (load_out) state_d = dtne_pkg::StIdle;
      default:            state_d = dtne_pkg::StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtne_pkg::StClear;
      clr_q   <= '0;
      top_q   <= dtne_pkg::TopDepthRst;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == dtne_pkg::StClear) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) top_q <= cfg_wdata_i;
      if (load_out) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      if (state_q == dtne_pkg::StSquare) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
      if (state_q == dtne_pkg::StRoot && state_d == dtne_pkg::StRoot) step_q <= step_q + 1'b1;
      else if (state_q == dtne_pkg::StDivide) step_q <= step_q + 1'b1;
      else step_q <= '0;
    end
  end

  // datapath: capture, squares, root, divide, output
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q    <= s_axis_tdata[7:0];
      y_q    <= s_axis_tdata[15:8];
      z_q    <= s_axis_tdata[47:16];
      g_q[0] <= s_axis_tdata[79:48];
      g_q[1] <= s_axis_tdata[111:80];
      g_q[2] <= s_axis_tdata[143:112];
    end
    // top depth hit gives the upward normal
    if (state_q == dtne_pkg::StTest) begin
      word_q <= dtne_pkg::TopWord;
      acc_q  <= '0;
    end
    // one square per cycle, registered in prod_q and then added to the sum
    if (state_q == dtne_pkg::StSquare) begin
      prod_q <= 64'(mag) * 64'(mag);
      if (cnt_q != 2'd0) acc_q <= acc_q + prod_q;
      rem_q  <= acc_q + prod_q;
      res_q  <= '0;
      bit_q  <= 64'h4000000000000000;
    end
    // bitwise integer square root, one result bit per cycle
    if (state_q == dtne_pkg::StRoot) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    // three restoring dividers, one quotient bit per cycle, msb first
    if (state_q == dtne_pkg::StDivide) begin
      if (len == 32'd0) begin
        word_q <= dtne_pkg::FlatWord;
      end else begin
        for (int i = 0; i < 3; i++) begin
          logic [40:0] den;
          logic [40:0] cur;
          logic [32:0] sum;
          den = 41'({len, 1'b0}) << (3'd7 - step_q[2:0]);
          sum = 33'($signed(g_q[i])) + 33'(len);
          cur = (step_q == 5'd0) ? ((41'(sum) << 8) - 41'(sum)) : num_q[i];
          if (cur >= den) begin
            num_q[i] <= cur - den;
            quo_q[i] <= (step_q == 5'd0) ? 8'(8'd1 << 7)
                                         : (quo_q[i] | (8'd1 << (3'd7 - step_q[2:0])));
          end else begin
            num_q[i] <= cur;
            quo_q[i] <= (step_q == 5'd0) ? 8'd0 : quo_q[i];
          end
        end
        if (step_q == 5'd7) begin
          word_q <= '0;
        end
      end
    end
    if (load_out) begin
      od_q <= {(word_q == '0) ? {dtne_pkg::AlphaByte, quo_q[2], quo_q[1], quo_q[0]} : word_q,
               32'(z_q), y_q, x_q};
    end
  end

endmodule

// ===== rtl/dtne_checker.sv =====
// port-level checks for the depth test and normal encode block
// depends on depth_test_normal_encode ports; bound to the top level below
module dtne_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [79:0]  m_axis_tdata
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every normal word carries an opaque alpha byte
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[79:72] == 8'hff)
    else $error("alpha byte wrong");

  // one sample at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after transfer");

  // no result can appear the cycle after an input transfer
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result too early");

endmodule

bind depth_test_normal_encode dtne_checker u_dtne_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/depth_test_normal_encode_tb.sv =====
// testbench for depth_test_normal_encode: streams surface samples, predicts the
// depth test and normal word per sample and checks every result transfer
// depends on dtne_pkg and the depth_test_normal_encode rtl
`timescale 1ns / 100ps

module depth_test_normal_encode_tb;

  localparam int          CycleLimit = 1000000;
  localparam int          SettleCycles = 64;
  localparam int          HoldCycles = 400;
  localparam logic [31:0] DepthMin = 32'h80000000;
  localparam logic [31:0] DepthMax = 32'h7fffffff;

  typedef struct packed {
    logic [31:0] gz;
    logic [31:0] gy;
    logic [31:0] gx;
    logic [31:0] depth;
    logic [7:0]  py;
    logic [7:0]  px;
  } sample_t;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] depth;
    logic [7:0]  y;
    logic [7:0]  x;
  } pixel_write_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // pixel_x, pixel_y, sample_depth, grad_x, grad_y, grad_z
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // out_x, out_y, new_depth, normal_word
  logic [79:0]  m_axis_tdata;
  logic         cfg_we_i;
  logic [31:0]  cfg_wdata_i;

  // predictor state
  logic signed [31:0] depth_mirror [65536];
  logic signed [31:0] top_depth_q;
  pixel_write_t       pending_writes[$];
  int                 errors = 0;
  int                 cycle_cnt = 0;
  bit                 pressure_arm;
  logic               hold_off = 1'b0;

  depth_test_normal_encode uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // integer square root, floor
  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned rem, res, bitv;
    rem = v;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_mag(input logic signed [31:0] g);
    longint unsigned a;
    a = (g < 0) ? longint'(-longint'(g)) : longint'(g);
    return a * a;
  endfunction

  // one normal byte from a gradient component and the vector length
  function automatic logic [7:0] normal_byte(input logic signed [31:0] g,
                                             input longint unsigned len);
    longint num, q;
    if (len == 0) return 8'd127;
    num = 255 * (longint'(g) + longint'(len));
    if (num < 0) num = 0;
    q = num / (2 * longint'(len));
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // depth test and normal encode for one accepted sample
  task automatic predict_normal_write(input sample_t s);
    pixel_write_t    w;
    longint unsigned len;
    int              idx;
    idx = {s.py, s.px};
    if (!(depth_mirror[idx] < $signed(s.depth))) return;
    depth_mirror[idx] = s.depth;
    w.x = s.px;
    w.y = s.py;
    w.depth = s.depth;
    if ($signed(s.depth) == top_depth_q) begin
      w.word = dtne_pkg::TopWord;
    end else begin
      len = isqrt64(sq_mag(s.gx) + sq_mag(s.gy) + sq_mag(s.gz));
      w.word = {dtne_pkg::AlphaByte, normal_byte(s.gz, len), normal_byte(s.gy, len),
                normal_byte(s.gx, len)};
    end
    pending_writes.insert(pending_writes.size(), w);
  endtask

  // transfer monitor: check results first, then predict new samples
  always @(posedge clk_i) begin
    pixel_write_t got, exp_w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_writes.size() == 0) begin
          $error("result with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          exp_w = pending_writes[0];
          pending_writes.delete(0);
          if (got.x != exp_w.x) begin
            $error("out_x expected %0d actual %0d", exp_w.x, got.x); errors++;
          end
          if (got.y != exp_w.y) begin
            $error("out_y expected %0d actual %0d", exp_w.y, got.y); errors++;
          end
          if (got.depth != exp_w.depth) begin
            $error("new_depth expected %h actual %h", exp_w.depth, got.depth); errors++;
          end
          if (got.word != exp_w.word) begin
            $error("normal_word expected %h actual %h", exp_w.word, got.word); errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_normal_write(s_axis_tdata);
    end
  end

  // receiver stall pattern in one of four randomly chosen modes
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (cycle_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= !hold_off;
      1: m_axis_tready <= !hold_off && ($urandom_range(0, 9) > 2);
      2: m_axis_tready <= !hold_off && ($urandom_range(0, 9) > 7);
      default: m_axis_tready <= !hold_off && cycle_cnt[2];
    endcase
  end

  // long receiver hold-off, counted here
  always begin
    wait (pressure_arm);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
    wait (!pressure_arm);
  end

  // sender burst state
  int burst_left;

  // one sample transfer, then maybe a gap
  task automatic send_sample(input sample_t s);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until every expected result has arrived and the block has settled
  task automatic drain();
    stop_sending();
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_top_depth(input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    top_depth_q = v;
    @(posedge clk_i);
  endtask

  function automatic sample_t mk(input logic [7:0] px, input logic [7:0] py,
                                 input logic [31:0] d, input logic [31:0] gx,
                                 input logic [31:0] gy, input logic [31:0] gz);
    sample_t s;
    s.px = px; s.py = py; s.depth = d; s.gx = gx; s.gy = gy; s.gz = gz;
    return s;
  endfunction

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1, 2: return $urandom;
      3: return $urandom_range(0, 4000) - 2000;
      4: return $urandom_range(0, 32'h40000) - 32'h20000;
      default: begin
        case ($urandom_range(0, 3))
          0: return DepthMin;
          1: return DepthMax;
          2: return 32'd1;
          default: return 32'hffffffff;
        endcase
      end
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int      idx;
    // a small pixel region makes the depth test fail often
    if ($urandom_range(0, 1)) begin
      s.px = 8'($urandom_range(0, 7));
      s.py = 8'($urandom_range(0, 3));
    end else begin
      s.px = 8'($urandom);
      s.py = 8'($urandom);
    end
    idx = {s.py, s.px};
    case ($urandom_range(0, 7))
      0: s.depth = top_depth_q;
      1: s.depth = DepthMin;
      2: s.depth = depth_mirror[idx];
      3, 4: s.depth = depth_mirror[idx] + $urandom_range(1, 5000);
      default: s.depth = $urandom;
    endcase
    s.gx = rand_grad();
    s.gy = rand_grad();
    s.gz = rand_grad();
    if ($urandom_range(0, 9) == 0) begin
      s.gx = 0; s.gy = 0; s.gz = 0;
    end
    return s;
  endfunction

  // extremes and special cases
  task automatic test_directed();
    write_top_depth(DepthMax);
    send_sample(mk(8'd0, 8'd0, 32'h00010000, 0, 0, 0));
    send_sample(mk(8'd255, 8'd255, DepthMax, 32'h00010000, 0, 0));
    send_sample(mk(8'd255, 8'd0, DepthMin, 32'h00010000, 0, 0));
    send_sample(mk(8'd0, 8'd255, 32'hfffe0000, DepthMin, DepthMin, DepthMin));
    send_sample(mk(8'd1, 8'd0, 32'd5, DepthMax, DepthMax, DepthMax));
    send_sample(mk(8'd2, 8'd0, 32'd5, DepthMin, 0, 0));
    send_sample(mk(8'd3, 8'd0, 32'd5, 0, DepthMax, 0));
    send_sample(mk(8'd4, 8'd0, 32'd5, 0, 0, DepthMin));
    send_sample(mk(8'd5, 8'd0, 32'd5, 32'hffffffff, 32'd1, 32'hffffffff));
    send_sample(mk(8'd6, 8'd0, 32'd5, 32'h00030000, 32'hfffc0000, 32'h0));
    // same pixel: lower, then equal, then in front
    send_sample(mk(8'd0, 8'd0, 32'h00008000, 32'd7, 0, 0));
    send_sample(mk(8'd0, 8'd0, 32'h00010000, 32'd7, 0, 0));
    send_sample(mk(8'd0, 8'd0, 32'h00010001, 32'd7, 32'd7, 0));
    send_sample(mk(8'd7, 8'd9, 32'h12345678, 32'hffff0000, 32'h00010000, 0));
    send_sample(mk(8'd255, 8'd255, DepthMax, 32'd3, 0, 0));
    drain();
  endtask

  // top depth at its minimum, just below its maximum and in between
  task automatic test_top_depth_sweep();
    logic [31:0] tops [4];
    sample_t     s;
    tops[0] = DepthMin; tops[1] = 32'd0; tops[2] = $urandom; tops[3] = DepthMax - 1;
    foreach (tops[i]) begin
      write_top_depth(tops[i]);
      for (int k = 0; k < 20; k++) begin
        s = rand_sample();
        if (k % 2 == 0) begin
          s.px = 8'd100 + k[7:0];
          s.py = 8'd40 + i[7:0];
          s.depth = tops[i];
        end
        send_sample(s);
      end
      drain();
    end
  endtask

  // random samples with a new top depth every few hundred
  task automatic test_random_samples();
    for (int n = 0; n < 1600; n++) begin
      if (n % 400 == 399) begin
        drain();
        write_top_depth($urandom_range(0, 1) ? $urandom : DepthMax);
      end
      send_sample(rand_sample());
    end
    drain();
  endtask

  // receiver holds off while samples keep coming
  task automatic test_backpressure();
    pressure_arm = 1'b1;
    for (int n = 0; n < 60; n++) send_sample(rand_sample());
    pressure_arm = 1'b0;
    drain();
  endtask

  initial begin
    pressure_arm = 1'b0;
    burst_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    foreach (depth_mirror[i]) depth_mirror[i] = dtne_pkg::DepthClear;
    top_depth_q = dtne_pkg::TopDepthRst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_top_depth_sweep();
    test_random_samples();
    test_backpressure();

    if (pending_writes.size() != 0) begin
      $error("%0d results never arrived", pending_writes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
